// ===== hw/rtl/rpn_pkg.sv =====
package rpn_pkg;

	localparam int DATA_W        = 32;
	localparam int DEF_STACK_DEPTH = 32;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;
	localparam logic [1:0] ST_OVER  = 2'd3;

	typedef struct packed {
		logic push;
		logic pop;
	} rpn_cell_ctrl_t;

endpackage

// ===== hw/rtl/rpn_cell.sv =====
module rpn_cell
	import rpn_pkg::*;
(
	input  logic                clk,
	input  rpn_cell_ctrl_t      ctrl,
	input  logic [DATA_W-1:0]   push_in,
	input  logic [DATA_W-1:0]   pop_in,
	output logic [DATA_W-1:0]   data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			data_q <= push_in;
		end else if (ctrl.pop) begin
			data_q <= pop_in;
		end
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/rpn_div.sv =====
module rpn_div
	import rpn_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DATA_W-1:0]   dividend,
	input  logic [DATA_W-1:0]   divisor,
	output logic                done,
	output logic [DATA_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;

	assign mag_a   = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
	assign mag_b   = divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
	assign shifted = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= diff[DATA_W] ? shifted : diff;
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;

endmodule

// ===== hw/rtl/postfix_expression_evaluator_unit.sv =====
// Postfix expression evaluator. Characters arrive on the input channel
// (in_valid, in_ready, ch, is_last); a request is taken when in_valid and
// in_ready are both high. Digits build a pending number, other characters
// push it, and the four arithmetic operators combine the two top entries.
// The operand stack is a row of cells that shift toward the bottom on a
// push and toward the top when two entries are combined into one.
// A digit or a separator is handled in the idle state. An add, subtract or
// multiply passes through take, compute and write back; a divide also waits
// for the one-bit-per-cycle divider between compute and write back. After
// the request marked last, a finishing step posts the result.
// The result (value, status) appears on the output channel in the cycle
// after the finishing step and waits in an output register until out_ready.
// Further requests are taken while it waits; only the next finishing step
// stalls until the output register is free. Status is sticky per
// expression: 0 ok, 1 stack underflow, 2 divide by zero, 3 stack overflow.
// Reset clears the stack count, pending number, status and output valid;
// stack contents are not cleared and need no clearing pass.
module postfix_expression_evaluator_unit
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          ch,
	input  logic                is_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  value,
	output logic [1:0]          status
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_OP   = 5'b00010,
		S_DIV  = 5'b00100,
		S_WB   = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	state_t            state_q;
	op_t               op_q;
	logic              last_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] accum_q;
	logic              digit_q;
	logic [1:0]        err_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [1:0]        out_status_q;
	logic [DATA_W-1:0] res_q;

	logic              take;
	logic              is_digit;
	logic              is_op;
	op_t               op_dec;
	logic              full;
	logic              fin_go;
	logic [DATA_W-1:0] accum_next;
	logic [DATA_W-1:0] top_a;
	logic [DATA_W-1:0] top_b;
	logic [DATA_W-1:0] prod;
	rpn_cell_ctrl_t    cell_ctrl;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W-1:0] cell_data [STACK_DEPTH];

	assign in_ready   = (state_q == S_IDLE);
	assign take       = in_valid && in_ready;
	assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign full       = (count_q == CNT_W'(STACK_DEPTH));
	assign fin_go     = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign accum_next = {accum_q[DATA_W-4:0], 3'b000} + {accum_q[DATA_W-2:0], 1'b0}
		+ DATA_W'(ch - CH_ZERO);
	assign top_b      = cell_data[0];
	assign top_a      = cell_data[1];
	assign prod       = top_a * top_b;

	always_comb begin
		is_op  = 1'b1;
		op_dec = OP_ADD;
		case (ch)
			CH_PLUS:  op_dec = OP_ADD;
			CH_MINUS: op_dec = OP_SUB;
			CH_STAR:  op_dec = OP_MUL;
			CH_SLASH: op_dec = OP_DIV;
			default:  is_op  = 1'b0;
		endcase
	end

	always_comb begin
		cell_ctrl = '0;
		if (take && !is_digit && digit_q && !full) begin
			cell_ctrl.push = 1'b1;
		end
		if (state_q == S_WB) begin
			cell_ctrl.pop = 1'b1;
		end
	end

	assign div_start = (state_q == S_OP) && (count_q >= CNT_W'(2)) && (op_q == OP_DIV)
		&& (top_b != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			last_q      <= 1'b0;
			count_q     <= '0;
			accum_q     <= '0;
			digit_q     <= 1'b0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						last_q <= is_last;
						op_q   <= op_dec;
						if (is_digit) begin
							digit_q <= 1'b1;
							accum_q <= accum_next;
						end else begin
							if (digit_q) begin
								if (full) begin
									if (err_q == ST_OK) begin
										err_q <= ST_OVER;
									end
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							digit_q <= 1'b0;
							accum_q <= '0;
						end
						if (!is_digit && is_op) begin
							state_q <= S_OP;
						end else if (is_last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_OP: begin
					if (count_q < CNT_W'(2)) begin
						if (err_q == ST_OK) begin
							err_q <= ST_UNDER;
						end
						state_q <= last_q ? S_FIN : S_IDLE;
					end else if (op_q == OP_DIV) begin
						if (top_b == '0) begin
							if (err_q == ST_OK) begin
								err_q <= ST_DIVZ;
							end
							state_q <= last_q ? S_FIN : S_IDLE;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						state_q <= S_WB;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (fin_go) begin
						count_q <= '0;
						accum_q <= '0;
						digit_q <= 1'b0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OP) begin
			case (op_q)
				OP_ADD:  res_q <= top_a + top_b;
				OP_SUB:  res_q <= top_a - top_b;
				OP_MUL:  res_q <= prod;
				default: res_q <= top_b;
			endcase
		end else if (div_done) begin
			res_q <= div_q;
		end
		if (fin_go) begin
			out_value_q  <= (count_q == '0) ? accum_q : cell_data[0];
			out_status_q <= err_q;
		end
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (top_a),
		.divisor  (top_b),
		.done     (div_done),
		.quotient (div_q)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] push_in;
		logic [DATA_W-1:0] pop_in;
		if (i == 0) begin : g_top
			assign push_in = accum_q;
			assign pop_in  = res_q;
		end else if (i == STACK_DEPTH - 1) begin : g_bottom
			assign push_in = cell_data[i-1];
			assign pop_in  = cell_data[i];
		end else begin : g_mid
			assign push_in = cell_data[i-1];
			assign pop_in  = cell_data[i+1];
		end
		rpn_cell u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl),
			.push_in (push_in),
			.pop_in  (pop_in),
			.data    (cell_data[i])
		);
	end

	assign out_valid = out_valid_q;
	assign value     = out_value_q;
	assign status    = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("Stack count exceeds the stack depth.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("Divider finished outside the divide state.");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> count_q == '0 && err_q == ST_OK && !digit_q && out_valid_q)
		else $error("Finishing step did not clear the expression state.");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !fin_go) |=> $stable(err_q))
		else $error("Status changed before the expression finished.");

	a_wb_has_operands: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |-> count_q >= CNT_W'(2))
		else $error("Write back with fewer than two stack entries.");

endmodule
